>>> src/buddy_tree_bitmap_allocator_defines.svh
// Assertion macros for the buddy tree bitmap allocator checker.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef BUDDY_TREE_BITMAP_ALLOCATOR_DEFINES_SVH
`define BUDDY_TREE_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle property, disabled during reset.
`define BTBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property of the form a |=> b, disabled during reset.
`define BTBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/btba_pkg.sv
// Shared types and constants of the buddy tree bitmap allocator.
// Used by btba_ctrl, btba_dp, the top level, the checker and the bench; depends on nothing.
package btba_pkg;

  localparam int unsigned TREE_LEVELS_DEF = 10;
  localparam int unsigned NODE_W          = 10;
  localparam int unsigned THR_W           = 24;
  localparam int unsigned SIZE_W          = 24;
  localparam int unsigned KIND_W          = 2;
  localparam logic [THR_W-1:0] FULL_THR_RST = 24'd524289;

  // Input beat layout in tdata, lowest bit first.
  localparam int unsigned FIRST_LSB = 0;
  localparam int unsigned LAST_LSB  = FIRST_LSB + NODE_W;
  localparam int unsigned NODE_LSB  = LAST_LSB + NODE_W;
  localparam int unsigned BIT_POS   = NODE_LSB + NODE_W;
  localparam int unsigned SIZE_LSB  = BIT_POS + 1;
  localparam int unsigned IN_DATA_W = ((SIZE_LSB + SIZE_W + 7) / 8) * 8;

  // Output beat layout in tdata, lowest bit first.
  localparam int unsigned OUT_BIT_POS  = NODE_W;
  localparam int unsigned OUT_FULL_POS = NODE_W + 1;
  localparam int unsigned OUT_DATA_W   = ((OUT_FULL_POS + 1 + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIND  = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_ALLOC_WR,
    ST_READ_CHK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clr_step;
    logic take_in;
    logic alloc_start;
    logic scan_start;
    logic scan_next;
    logic rd_scan;
    logic walk_start;
    logic rd_walk;
    logic walk_up;
    logic wr_alloc;
    logic wr_bit;
    logic rd_node;
    logic set_found;
    logic set_bitout;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  clr_done;
    logic  find_ok;
    logic  node_ok;
    logic  bit_a;
    logic  bit_b;
    logic  scan_end;
    logic  cur_zero;
    logic  par_zero;
    logic  out_free;
  } sts_t;

endpackage

>>> src/btba_dp.sv
// Datapath of the buddy tree bitmap allocator: tree bitmap memory, request
// registers, scan and walk pointers, flags and the output register. Uses btba_pkg.
module btba_dp import btba_pkg::*; #(
  parameter int unsigned TREE_LEVELS = TREE_LEVELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [THR_W-1:0]      cfg_wdata_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic [KIND_W-1:0]     in_kind_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_found_o
);

  localparam int unsigned IW    = (TREE_LEVELS > NODE_W) ? TREE_LEVELS : NODE_W;
  localparam int unsigned Depth = 1 << TREE_LEVELS;
  localparam logic [IW-1:0] NodeCount = IW'((1 << TREE_LEVELS) - 1);
  localparam logic [IW-1:0] One = IW'(1);
  localparam logic [IW-1:0] Two = IW'(2);

  // request registers
  kind_e             kind_q;
  logic [NODE_W-1:0] first_q, last_q, node_q;
  logic              bit_q;
  logic [SIZE_W-1:0] size_q;

  logic [THR_W-1:0]   thr_q;
  logic               first_alloc_q, full_q;
  logic [TREE_LEVELS:0] clr_cnt_q;

  logic [IW-1:0] idx_q, lastc_q, cur_q;
  logic [IW-1:0] first_w, last_w, node_w, par, sib, lastc;

  logic mem_q [Depth];
  logic rd_a_q, rd_b_q;
  logic mem_we, mem_wdata, rd_en;
  logic [TREE_LEVELS-1:0] mem_waddr, raddr_a, raddr_b;

  logic              res_found_q, res_bit_q;
  logic [NODE_W-1:0] res_free_q;

  logic              out_valid_q, out_found_q, out_bit_q, out_full_q;
  logic [NODE_W-1:0] out_free_q;

  assign first_w = IW'(first_q);
  assign last_w  = IW'(last_q);
  assign node_w  = IW'(node_q);
  assign par     = (cur_q - One) >> 1;
  assign sib     = cur_q[0] ? (cur_q + One) : (cur_q - One);
  assign lastc   = (last_w >= NodeCount) ? (NodeCount - One) : last_w;

  always_comb begin
    sts_o.kind     = kind_q;
    sts_o.clr_done = clr_cnt_q[TREE_LEVELS];
    sts_o.find_ok  = !full_q && (first_q <= last_q) && (first_w < NodeCount);
    sts_o.node_ok  = node_w < NodeCount;
    sts_o.bit_a    = rd_a_q;
    sts_o.bit_b    = rd_b_q;
    sts_o.scan_end = idx_q == lastc_q;
    sts_o.cur_zero = cur_q == '0;
    sts_o.par_zero = cur_q <= Two;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = 1'b0;
    mem_waddr = cur_q[TREE_LEVELS-1:0];
    if (cmd_i.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q[TREE_LEVELS-1:0];
    end else if (cmd_i.wr_bit) begin
      mem_we    = node_w < NodeCount;
      mem_wdata = bit_q;
      mem_waddr = node_w[TREE_LEVELS-1:0];
    end else if (cmd_i.wr_alloc) begin
      mem_we    = 1'b1;
      mem_wdata = 1'b1;
    end
    rd_en   = cmd_i.rd_scan || cmd_i.rd_walk || cmd_i.rd_node;
    raddr_b = sib[TREE_LEVELS-1:0];
    if (cmd_i.rd_scan) begin
      raddr_a = idx_q[TREE_LEVELS-1:0];
    end else if (cmd_i.rd_walk) begin
      raddr_a = par[TREE_LEVELS-1:0];
    end else begin
      raddr_a = node_w[TREE_LEVELS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_a_q <= mem_q[raddr_a];
      rd_b_q <= mem_q[raddr_b];
    end
  end

  // control state of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q     <= '0;
      thr_q         <= FULL_THR_RST;
      first_alloc_q <= 1'b1;
      full_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (cmd_i.alloc_start && first_alloc_q && (size_q >= thr_q)) begin
        full_q <= 1'b1;
      end
      if (cmd_i.wr_alloc && (cur_q == '0)) begin
        first_alloc_q <= 1'b0;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      kind_q      <= kind_e'(in_kind_i);
      first_q     <= in_data_i[FIRST_LSB +: NODE_W];
      last_q      <= in_data_i[LAST_LSB +: NODE_W];
      node_q      <= in_data_i[NODE_LSB +: NODE_W];
      bit_q       <= in_data_i[BIT_POS];
      size_q      <= in_data_i[SIZE_LSB +: SIZE_W];
      res_found_q <= 1'b0;
      res_free_q  <= '0;
      res_bit_q   <= 1'b0;
    end
    if (cmd_i.scan_start) begin
      idx_q   <= first_w;
      lastc_q <= lastc;
    end else if (cmd_i.scan_next) begin
      idx_q <= idx_q + One;
    end
    if (cmd_i.alloc_start) begin
      cur_q <= node_w;
    end else if (cmd_i.walk_start) begin
      cur_q <= idx_q;
    end else if (cmd_i.walk_up || cmd_i.wr_alloc) begin
      cur_q <= par;
    end
    if (cmd_i.set_found) begin
      res_found_q <= 1'b1;
      res_free_q  <= idx_q[NODE_W-1:0];
    end
    if (cmd_i.set_bitout) begin
      res_bit_q <= rd_a_q;
    end
    if (cmd_i.load_out) begin
      out_found_q <= res_found_q;
      out_free_q  <= res_free_q;
      out_bit_q   <= res_bit_q;
      out_full_q  <= full_q;
    end
  end

  always_comb begin
    out_data_o                  = '0;
    out_data_o[NODE_W-1:0]      = out_free_q;
    out_data_o[OUT_BIT_POS]     = out_bit_q;
    out_data_o[OUT_FULL_POS]    = out_full_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_found_o = out_found_q;

endmodule

>>> src/btba_ctrl.sv
// Controller of the buddy tree bitmap allocator: sequences the clearing pass,
// scan, ancestor walk, allocation and bit requests. Uses btba_pkg.
module btba_ctrl import btba_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (sts_i.kind)
          KIND_FIND:  state_d = sts_i.find_ok ? ST_SCAN_RD : ST_DONE;
          KIND_ALLOC: state_d = sts_i.node_ok ? ST_ALLOC_WR : ST_DONE;
          KIND_READ:  state_d = sts_i.node_ok ? ST_READ_CHK : ST_DONE;
          default:    state_d = ST_DONE;
        endcase
      end
      ST_SCAN_RD:  state_d = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (!sts_i.bit_a) begin
          state_d = ST_WALK_RD;
        end else begin
          state_d = sts_i.scan_end ? ST_DONE : ST_SCAN_RD;
        end
      end
      ST_WALK_RD: begin
        state_d = sts_i.par_zero ? ST_DONE : ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (!sts_i.bit_a) begin
          state_d = ST_WALK_RD;
        end else if (sts_i.bit_b || sts_i.scan_end) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_ALLOC_WR: begin
        if (sts_i.cur_zero) state_d = ST_DONE;
      end
      ST_READ_CHK: state_d = ST_DONE;
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: cmd_o.clr_step = !sts_i.clr_done;
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.take_in = in_valid_i;
      end
      ST_DISPATCH: begin
        case (sts_i.kind)
          KIND_FIND:  cmd_o.scan_start  = sts_i.find_ok;
          KIND_ALLOC: cmd_o.alloc_start = sts_i.node_ok;
          KIND_WRITE: cmd_o.wr_bit      = 1'b1;
          KIND_READ:  cmd_o.rd_node     = sts_i.node_ok;
          default:    cmd_o.wr_bit      = 1'b0;
        endcase
      end
      ST_SCAN_RD: cmd_o.rd_scan = 1'b1;
      ST_SCAN_CHK: begin
        cmd_o.walk_start = !sts_i.bit_a;
        cmd_o.scan_next  = sts_i.bit_a && !sts_i.scan_end;
      end
      ST_WALK_RD: begin
        // root's children and the root itself are always usable
        cmd_o.set_found = sts_i.par_zero;
        cmd_o.rd_walk   = !sts_i.par_zero;
      end
      ST_WALK_CHK: begin
        cmd_o.walk_up   = !sts_i.bit_a;
        cmd_o.set_found = sts_i.bit_a && sts_i.bit_b;
        cmd_o.scan_next = sts_i.bit_a && !sts_i.bit_b && !sts_i.scan_end;
      end
      ST_ALLOC_WR: cmd_o.wr_alloc   = 1'b1;
      ST_READ_CHK: cmd_o.set_bitout = 1'b1;
      ST_DONE:     cmd_o.load_out   = sts_i.out_free;
      default:     cmd_o.clr_step   = 1'b0;
    endcase
  end

endmodule

>>> src/buddy_tree_bitmap_allocator.sv
// Buddy tree bitmap allocator, one bit per node in heap order.
// Slave beats carry requests, master beats carry one result per request.
// Request kinds on s_axis_tuser: find free node, allocate node and ancestors,
// write one bit, read one bit. full_threshold is written on cfg_we_i.
// After reset the tree memory is cleared one entry per cycle, all 2^TREE_LEVELS
// entries (1024 at the default), and s_axis_tready rises once that pass is done;
// config writes are taken meanwhile. One request is worked on at a time; the
// controller loops over a single memory with two registered read ports.
// A write, and any out-of-range request, goes straight to the result; a read
// reads its node first. A find scans its range node by node and, for a clear
// node, walks up its ancestors; it ends at the first usable node. An allocation
// sets the node and then each ancestor up to the root.
// A result waits in the output register while m_axis_tready is low; the next
// request is accepted meanwhile, and its result is held back until the
// waiting beat leaves. Each request passes through idle before the next is taken.
// Uses btba_pkg, btba_ctrl and btba_dp.
module buddy_tree_bitmap_allocator import btba_pkg::*; #(
  parameter int unsigned TREE_LEVELS = TREE_LEVELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [THR_W-1:0]      cfg_wdata_i,    // full_threshold
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // range_first, range_last, node_index, bit_in, request_size, zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [KIND_W-1:0]     s_axis_tuser,   // kind
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // free_node, bit_out, memory_full, zero fill
  output logic                  m_axis_tuser    // found
);

  cmd_t cmd;
  sts_t sts;

  btba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  btba_dp #(
    .TREE_LEVELS (TREE_LEVELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_kind_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_found_o (m_axis_tuser)
  );

endmodule

>>> src/btba_checker.sv
// Port-level checker for the buddy tree bitmap allocator, bound to the top.
// Uses btba_pkg and the assertion macros header.
`include "buddy_tree_bitmap_allocator_defines.svh"

module btba_checker import btba_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  logic              out_stall, out_hit, out_miss, out_bit, out_full, out_full_beat;
  logic [NODE_W-1:0] out_node;
  logic [OUT_DATA_W:0] out_beat;

  assign out_stall     = m_axis_tvalid && !m_axis_tready;
  assign out_hit       = m_axis_tvalid && m_axis_tuser;
  assign out_miss      = m_axis_tvalid && !m_axis_tuser;
  assign out_node      = m_axis_tdata[NODE_W-1:0];
  assign out_bit       = m_axis_tdata[OUT_BIT_POS];
  assign out_full      = m_axis_tdata[OUT_FULL_POS];
  assign out_full_beat = m_axis_tvalid && out_full;
  assign out_beat      = {m_axis_tuser, m_axis_tdata};

  `BTBA_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_beat), "stalled beat changed")
  `BTBA_ASSERT(a_miss_zero, !(out_miss && (out_node != '0)), "not-found beat carries a node")
  `BTBA_ASSERT(a_found_not_full, !(out_hit && out_full), "node found while memory is full")
  `BTBA_ASSERT(a_found_no_bit, !(out_hit && out_bit), "find beat carries a read bit")
  `BTBA_ASSERT_NEXT(a_full_sticky, out_full_beat, !m_axis_tvalid || out_full, "full flag dropped")

endmodule

bind buddy_tree_bitmap_allocator btba_checker u_btba_checker (.*);

>>> tb/buddy_tree_bitmap_allocator_test.sv
`timescale 1ns / 1ps
// Self-checking bench for buddy_tree_bitmap_allocator: drives request beats, predicts each
// result from a bit-level copy of the tree, flags and threshold, and compares every beat.
// Depends on btba_pkg and the RTL of the allocator.

module buddy_tree_bitmap_allocator_test;
  import btba_pkg::*;

  localparam int NODE_CNT     = (1 << TREE_LEVELS_DEF) - 1;
  localparam int NODE_MAX_RAW = (1 << NODE_W) - 1;
  localparam int SIZE_MAX     = (1 << SIZE_W) - 1;
  localparam int CYCLE_LIMIT  = 100_000_000;
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] free_node;
    logic              bit_out;
    logic              mem_full;
  } alloc_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [THR_W-1:0]      cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [KIND_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  // Predicted block state.
  bit tree_q [NODE_CNT];
  bit first_alloc_q = 1'b1;
  bit full_q = 1'b0;
  int threshold_q = int'(FULL_THR_RST);

  alloc_result_t pending_results[$];
  int  err_count = 0;
  int  items_sent = 0;
  int  cycle_count = 0;
  bit  tx_gaps_on = 1'b1;
  bit  rx_stalls_on = 1'b1;
  int  rx_hold_len = 0;

  buddy_tree_bitmap_allocator #(
    .TREE_LEVELS(TREE_LEVELS_DEF)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic bit node_bit(int n);
    return (n < NODE_CNT) ? tree_q[n] : 1'b0;
  endfunction

  // Walk up from n; the nearest set ancestor below the root decides, through the
  // buddy of the child that lies on the path.
  function automatic bit buddy_path_ok(int n);
    int cur;
    int par;
    cur = n;
    while (cur > 0) begin
      par = (cur - 1) >> 1;
      if (par == 0) return 1'b1;
      if (node_bit(par)) return node_bit(cur[0] ? cur + 1 : cur - 1);
      cur = par;
    end
    return 1'b1;
  endfunction

  function automatic alloc_result_t predict_alloc_result(kind_e kind, int first, int last,
                                                         int node, bit bit_in, int size);
    alloc_result_t res;
    int hi;
    int cur;
    res = '0;
    case (kind)
      KIND_FIND: begin
        if (!full_q && first <= last && first < NODE_CNT) begin
          hi = (last >= NODE_CNT) ? NODE_CNT - 1 : last;
          for (int i = first; i <= hi; i++) begin
            if (!node_bit(i) && buddy_path_ok(i)) begin
              res.found = 1'b1;
              res.free_node = i[NODE_W-1:0];
              break;
            end
          end
        end
      end
      KIND_ALLOC: begin
        if (node < NODE_CNT) begin
          if (first_alloc_q && size >= threshold_q) full_q = 1'b1;
          cur = node;
          tree_q[cur] = 1'b1;
          while (cur != 0) begin
            cur = (cur - 1) >> 1;
            tree_q[cur] = 1'b1;
          end
          first_alloc_q = 1'b0;
        end
      end
      KIND_WRITE: begin
        if (node < NODE_CNT) tree_q[node] = bit_in;
      end
      default: res.bit_out = node_bit(node);
    endcase
    res.mem_full = full_q;
    return res;
  endfunction

  function automatic int pick_gap(bit enable);
    int r;
    if (!enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin : result_checker
    alloc_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("beat with no request pending", 32'(m_axis_tdata), 32'(0));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.found)
          report_mismatch("found", 32'(m_axis_tuser), 32'(want.found));
        if (m_axis_tdata[NODE_W-1:0] !== want.free_node)
          report_mismatch("free_node", 32'(m_axis_tdata[NODE_W-1:0]), 32'(want.free_node));
        if (m_axis_tdata[OUT_BIT_POS] !== want.bit_out)
          report_mismatch("bit_out", 32'(m_axis_tdata[OUT_BIT_POS]), 32'(want.bit_out));
        if (m_axis_tdata[OUT_FULL_POS] !== want.mem_full)
          report_mismatch("memory_full", 32'(m_axis_tdata[OUT_FULL_POS]), 32'(want.mem_full));
      end
    end
  end

  // Result side: random stalls, or one long hold-off when a test asks for it.
  initial begin : rx_ready_driver
    int n;
    forever begin
      @(posedge clk_i);
      if (rx_hold_len > 0) begin
        n = rx_hold_len;
        rx_hold_len = 0;
      end else begin
        n = pick_gap(rx_stalls_on);
      end
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Leaves tvalid high after the handshake; the next call drops it only for a gap, a drain takes it down.
  task automatic send_request(input kind_e kind, input int first, input int last,
                              input int node, input bit bit_in, input int size);
    int gap;
    logic [IN_DATA_W-1:0] beat;
    gap = pick_gap(tx_gaps_on);
    beat = '0;
    beat[FIRST_LSB +: NODE_W] = first[NODE_W-1:0];
    beat[LAST_LSB +: NODE_W]  = last[NODE_W-1:0];
    beat[NODE_LSB +: NODE_W]  = node[NODE_W-1:0];
    beat[BIT_POS]             = bit_in;
    beat[SIZE_LSB +: SIZE_W]  = size[SIZE_W-1:0];
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_alloc_result(kind, first, last, node, bit_in, size));
    items_sent++;
  endtask

  task automatic send_find(input int first, input int last);
    send_request(KIND_FIND, first, last, $urandom_range(0, NODE_MAX_RAW),
                 1'($urandom_range(0, 1)), $urandom_range(0, SIZE_MAX));
  endtask

  task automatic send_alloc(input int node, input int size);
    send_request(KIND_ALLOC, $urandom_range(0, NODE_MAX_RAW), $urandom_range(0, NODE_MAX_RAW),
                 node, 1'($urandom_range(0, 1)), size);
  endtask

  task automatic send_write(input int node, input bit val);
    send_request(KIND_WRITE, $urandom_range(0, NODE_MAX_RAW), $urandom_range(0, NODE_MAX_RAW),
                 node, val, $urandom_range(0, SIZE_MAX));
  endtask

  task automatic send_read(input int node);
    send_request(KIND_READ, $urandom_range(0, NODE_MAX_RAW), $urandom_range(0, NODE_MAX_RAW),
                 node, 1'($urandom_range(0, 1)), $urandom_range(0, SIZE_MAX));
  endtask

  // Always advances the clock before checking, so back-to-back drains never drive tvalid twice at once.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_threshold(input int value);
    wait_results_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[THR_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    threshold_q = value;
  endtask

  // One random request or a short well-formed sequence of them.
  task automatic send_random_episode(input bit allow_alloc);
    int r;
    int s;
    int node;
    int first;
    int last;
    int levels;
    bit val;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      // set or clear a node and some of its ancestors, as an allocation would
      node = $urandom_range(0, NODE_CNT - 1);
      val = 1'($urandom_range(0, 1));
      levels = $urandom_range(1, TREE_LEVELS_DEF);
      repeat (levels) begin
        send_write(node, val);
        if (node == 0) break;
        node = (node - 1) >> 1;
      end
    end else if (r < 45) begin
      send_write($urandom_range(0, NODE_MAX_RAW), 1'($urandom_range(0, 1)));
    end else if (r < 75) begin
      first = $urandom_range(0, NODE_MAX_RAW);
      s = $urandom_range(0, 99);
      if (s < 3) begin
        first = $urandom_range(0, 31);
        last = NODE_MAX_RAW;
      end else if (s < 8) begin
        last = $urandom_range(0, NODE_MAX_RAW);
      end else if (s < 13) begin
        last = (first == 0) ? 0 : $urandom_range(0, first - 1);
      end else begin
        last = first + $urandom_range(0, 63);
        if (last > NODE_MAX_RAW) last = NODE_MAX_RAW;
      end
      send_find(first, last);
    end else if (r < 90) begin
      send_read($urandom_range(0, NODE_MAX_RAW));
    end else begin
      node = allow_alloc ? $urandom_range(0, NODE_MAX_RAW) : NODE_MAX_RAW;
      send_alloc(node, $urandom_range(0, SIZE_MAX));
    end
  endtask

  task automatic test_directed_requests();
    // threshold written and first request issued while the tree memory is still being cleared
    write_threshold(SIZE_MAX);
    send_read(0);
    send_read(NODE_CNT - 1);
    send_read(NODE_MAX_RAW);
    send_find(0, NODE_CNT - 1);
    send_find(5, 3);
    send_find(NODE_MAX_RAW, NODE_MAX_RAW);
    send_find(1000, NODE_MAX_RAW);
    send_write(0, 1'b1);
    send_write(1, 1'b1);
    send_write(3, 1'b1);
    send_find(3, 6);
    send_find(7, 7);
    // buddy of the start node set, buddy of the path child clear
    send_write(16, 1'b1);
    send_find(15, 15);
    send_write(8, 1'b1);
    send_find(15, 15);
    send_find(7, 7);
    send_write(8, 1'b0);
    send_read(8);
    send_read(16);
    // out-of-tree node: ignored, flags untouched
    send_write(NODE_MAX_RAW, 1'b1);
    send_read(NODE_MAX_RAW);
    send_alloc(NODE_MAX_RAW, SIZE_MAX);
    send_find(0, NODE_CNT - 1);
    wait_results_drained();
  endtask

  task automatic test_random_tree_phases();
    int limits[4];
    int target;
    limits = '{0, int'(FULL_THR_RST), $urandom_range(0, SIZE_MAX), SIZE_MAX};
    for (int p = 0; p < 4; p++) begin
      write_threshold(limits[p]);
      tx_gaps_on   = (p != 1);
      rx_stalls_on = (p != 2);
      target = items_sent + 240;
      while (items_sent < target) send_random_episode(1'b0);
      wait_results_drained();
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    int target;
    tx_gaps_on = 1'b0;
    rx_hold_len = 200;
    target = items_sent + 12;
    while (items_sent < target) send_random_episode(1'b0);
    wait_results_drained();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_first_allocation();
    int limit;
    int node;
    limit = $urandom_range(1, SIZE_MAX);
    node = $urandom_range(0, NODE_CNT - 1);
    write_threshold(limit);
    // size exactly at the threshold marks the memory full
    send_alloc(node, limit);
    send_find(0, NODE_CNT - 1);
    send_read(node);
    send_read(0);
    wait_results_drained();
  endtask

  task automatic test_random_after_full();
    int target;
    write_threshold(0);
    target = items_sent + 220;
    while (items_sent < target) send_random_episode(1'b1);
    wait_results_drained();
  endtask

  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    test_directed_requests();
    test_random_tree_phases();
    test_output_backpressure();
    test_first_allocation();
    test_random_after_full();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/btba_pkg.sv
src/btba_dp.sv
src/btba_ctrl.sv
src/buddy_tree_bitmap_allocator.sv
src/btba_checker.sv
tb/buddy_tree_bitmap_allocator_test.sv
